/* src/fpd_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package fpd_pkg;
    localparam int RING_DEPTH = 5;
    localparam int POS_W = $clog2(RING_DEPTH);
    localparam int DIV_CONST = RING_DEPTH - 2;
    localparam int SUM_W = 16 + $clog2(RING_DEPTH) + 2;
    localparam int NUM_W = 32;
    localparam int DEN_W = 32;
    localparam int CNT_W = 6;
    localparam int MEAN_SHIFT = SUM_W + 4;
    localparam int PROD_W = SUM_W + MEAN_SHIFT;
    localparam longint MEAN_RECIP = ((longint'(1) << MEAN_SHIFT) + DIV_CONST - 1) / DIV_CONST;

    localparam logic [2:0] CFG_LAUNCH = 3'd0;
    localparam logic [2:0] CFG_APOGEE = 3'd1;
    localparam logic [2:0] CFG_LANDED = 3'd2;
    localparam logic [2:0] CFG_HEIGHT = 3'd3;
    localparam logic [2:0] CFG_PERCENT = 3'd4;

    typedef enum logic [2:0] {
        PH_PAD = 3'd0,
        PH_ASCENT = 3'd1,
        PH_APOGEE = 3'd2,
        PH_DESCENT = 3'd3,
        PH_PROBE = 3'd4,
        PH_PAYLOAD = 3'd5,
        PH_LANDED = 3'd6
    } phase_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_SCAN,
        ST_MEAN,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic start;
        logic [NUM_W-1:0] num_mag;
        logic [DEN_W-1:0] den;
    } div_req_t;

    typedef struct packed {
        logic done;
        logic [NUM_W-1:0] quo;
    } div_rsp_t;
endpackage
`default_nettype wire

/* src/fpd_if.sv */
`timescale 1ns / 1ps
`default_nettype none
interface fpd_in_if;
    logic valid;
    logic ready;
    logic kind;
    logic signed [20:0] altitude;
    logic [31:0] time_ms;
    logic signed [20:0] peak_altitude;
    logic apogee_sent;
    logic payload_release_sent;
    modport source (output valid, kind, altitude, time_ms, peak_altitude, apogee_sent,
        payload_release_sent, input ready);
    modport sink (input valid, kind, altitude, time_ms, peak_altitude, apogee_sent,
        payload_release_sent, output ready);
endinterface

interface fpd_out_if;
    logic valid;
    logic ready;
    logic [2:0] phase;
    logic container_release_pulse;
    logic payload_release_pulse;
    logic container_dropped;
    logic payload_dropped;
    logic glider_deployed;
    logic signed [15:0] mean_rate;
    modport source (output valid, phase, container_release_pulse, payload_release_pulse,
        container_dropped, payload_dropped, glider_deployed, mean_rate, input ready);
    modport sink (input valid, phase, container_release_pulse, payload_release_pulse,
        container_dropped, payload_dropped, glider_deployed, mean_rate, output ready);
endinterface
`default_nettype wire

/* src/flight_phase_detector.sv */
`timescale 1ns / 1ps
`default_nettype none
// channel  dir  handshake     payload
// in_ch    in   valid/ready   kind, altitude, time_ms, peak_altitude, apogee_sent,
//                             payload_release_sent
// out_ch   out  valid/ready   phase, release pulses, flags, mean_rate
// cfg      in   cfg_we        cfg_index, cfg_data
// a flight sample is taken in idle, run through the bit-serial divider, then the ring
// is scanned, the trimmed sum and phase step are formed and the result is handed over;
// a restart item skips the divider, a sample with no elapsed time too
// rst_n clears ring, phase and flags, sets config defaults; one transaction at a time
// out_ch holds its result until taken, in_ch is not ready meanwhile
module flight_phase_detector
    import fpd_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    fpd_in_if.sink in_ch,
    fpd_out_if.source out_ch,
    input  wire logic cfg_we,
    input  wire logic [2:0] cfg_index,
    input  wire logic [20:0] cfg_data
);
    state_t state_reg, state_next;
    logic signed [15:0] launch_reg, apogee_reg, landed_reg;
    logic signed [20:0] height_reg;
    logic [6:0] percent_reg;

    logic signed [15:0] ring_reg [RING_DEPTH];
    logic [POS_W-1:0] pos_reg;
    logic signed [20:0] last_alt_reg;
    logic [31:0] last_time_reg;
    phase_t phase_reg;
    logic cflag_reg, pflag_reg, gflag_reg;
    logic cpulse_reg, ppulse_reg;

    logic kind_reg, apo_reg, pay_reg;
    logic signed [20:0] alt_reg, peak_reg;
    logic neg_reg;
    logic [POS_W-1:0] idx_reg;
    logic signed [SUM_W-1:0] sum_reg;
    logic signed [15:0] hi_reg, lo_reg;
    logic mneg_reg;
    logic [SUM_W-1:0] mag_reg;

    div_req_t dreq;
    div_rsp_t drsp;

    fpd_divider u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

    logic accept;
    logic signed [21:0] dalt;
    logic signed [31:0] num_s;
    logic [31:0] num_mag;
    logic [31:0] dt;
    logic signed [15:0] rate_sat;
    logic signed [SUM_W-1:0] ts;
    logic signed [SUM_W-1:0] lim_launch, lim_apogee, lim_landed;
    logic signed [28:0] alt100, peakpct;
    logic scan_last;
    logic [PROD_W-1:0] mean_prod;
    logic [SUM_W-1:0] mean_mag;

    assign accept = in_ch.valid && in_ch.ready;
    assign in_ch.ready = (state_reg == ST_IDLE);
    assign out_ch.valid = (state_reg == ST_OUT);
    assign dalt = 22'(in_ch.altitude) - 22'(last_alt_reg);
    // |dalt| * 1000 fits in 32 bits signed
    assign num_s = 32'(dalt) * 32'sd1000;
    assign num_mag = num_s[31] ? 32'(-num_s) : 32'(num_s);
    assign dt = in_ch.time_ms - last_time_reg;
    assign scan_last = (idx_reg == POS_W'(RING_DEPTH - 1));
    assign ts = sum_reg - SUM_W'(hi_reg) - SUM_W'(lo_reg);
    assign lim_launch = SUM_W'(launch_reg) * SUM_W'(DIV_CONST);
    assign lim_apogee = SUM_W'(apogee_reg) * SUM_W'(DIV_CONST);
    assign lim_landed = SUM_W'(landed_reg) * SUM_W'(DIV_CONST);
    assign alt100 = 29'(alt_reg) * 29'sd100;
    assign peakpct = 29'(peak_reg) * $signed({22'd0, percent_reg});
    // magnitude over the trimmed count by reciprocal multiply, exact over the sum range
    assign mean_prod = PROD_W'(mag_reg) * PROD_W'(MEAN_RECIP);
    assign mean_mag = mean_prod[PROD_W-1:MEAN_SHIFT];

    always_comb
    begin
        dreq.start = accept && in_ch.kind && (in_ch.time_ms != last_time_reg);
        dreq.num_mag = num_mag;
        dreq.den = dt;
    end

    always_comb
    begin
        if (neg_reg)
            rate_sat = (drsp.quo > 32'd32768) ? 16'sh8000 : 16'(-$signed(drsp.quo));
        else
            rate_sat = (drsp.quo > 32'd32767) ? 16'sh7fff : 16'(drsp.quo);
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
                if (accept)
                    state_next = dreq.start ? ST_DIV : ST_SCAN;
            ST_DIV:
                if (drsp.done)
                    state_next = ST_SCAN;
            ST_SCAN:
                if (scan_last)
                    state_next = ST_MEAN;
            ST_MEAN:
                state_next = ST_OUT;
            ST_OUT:
                if (out_ch.ready)
                    state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            launch_reg <= 16'sd500;
            apogee_reg <= -16'sd50;
            landed_reg <= -16'sd20;
            height_reg <= 21'sd300;
            percent_reg <= 7'd80;
            for (int i = 0; i < RING_DEPTH; i++)
                ring_reg[i] <= '0;
            pos_reg <= '0;
            last_alt_reg <= '0;
            last_time_reg <= '0;
            phase_reg <= PH_PAD;
            cflag_reg <= 1'b0;
            pflag_reg <= 1'b0;
            gflag_reg <= 1'b0;
            cpulse_reg <= 1'b0;
            ppulse_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_LAUNCH: launch_reg <= cfg_data[15:0];
                    CFG_APOGEE: apogee_reg <= cfg_data[15:0];
                    CFG_LANDED: landed_reg <= cfg_data[15:0];
                    CFG_HEIGHT: height_reg <= cfg_data;
                    CFG_PERCENT: percent_reg <= cfg_data[6:0];
                    default: ;
                endcase
            end
            if (accept)
            begin
                cpulse_reg <= 1'b0;
                ppulse_reg <= 1'b0;
                if (!in_ch.kind)
                begin
                    for (int i = 0; i < RING_DEPTH; i++)
                        ring_reg[i] <= '0;
                    last_alt_reg <= in_ch.altitude;
                    last_time_reg <= in_ch.time_ms;
                end
                else if (dreq.start)
                begin
                    last_alt_reg <= in_ch.altitude;
                    last_time_reg <= in_ch.time_ms;
                end
            end
            if (state_reg == ST_DIV && drsp.done)
            begin
                ring_reg[pos_reg] <= rate_sat;
                pos_reg <= (pos_reg == POS_W'(RING_DEPTH - 1)) ? '0 : pos_reg + 1'b1;
            end
            if (state_reg == ST_MEAN && kind_reg)
            begin
                unique case (phase_reg)
                    PH_PAD:
                        if (ts > lim_launch) phase_reg <= PH_ASCENT;
                    PH_ASCENT:
                        if (ts < lim_apogee) phase_reg <= PH_APOGEE;
                    PH_APOGEE:
                        if (apo_reg) phase_reg <= PH_DESCENT;
                    PH_DESCENT:
                        if (alt100 <= peakpct)
                        begin
                            phase_reg <= PH_PROBE;
                            cpulse_reg <= 1'b1;
                            cflag_reg <= 1'b1;
                            gflag_reg <= 1'b1;
                        end
                    PH_PROBE:
                        if (alt_reg <= height_reg || ts > lim_landed)
                        begin
                            phase_reg <= PH_PAYLOAD;
                            ppulse_reg <= 1'b1;
                            pflag_reg <= 1'b1;
                        end
                    PH_PAYLOAD:
                        if (ts > lim_landed && pay_reg)
                        begin
                            phase_reg <= PH_LANDED;
                            gflag_reg <= 1'b0;
                        end
                    default: ;
                endcase
            end
        end
    end

    // item capture, serial scan of the ring, then sign and magnitude of the trimmed sum
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            kind_reg <= in_ch.kind;
            apo_reg <= in_ch.apogee_sent;
            pay_reg <= in_ch.payload_release_sent;
            alt_reg <= in_ch.altitude;
            peak_reg <= in_ch.peak_altitude;
            neg_reg <= num_s[31];
            idx_reg <= '0;
            sum_reg <= '0;
            hi_reg <= 16'sh8000;
            lo_reg <= 16'sh7fff;
        end
        if (state_reg == ST_SCAN)
        begin
            sum_reg <= sum_reg + SUM_W'(ring_reg[idx_reg]);
            if (ring_reg[idx_reg] > hi_reg) hi_reg <= ring_reg[idx_reg];
            if (ring_reg[idx_reg] < lo_reg) lo_reg <= ring_reg[idx_reg];
            idx_reg <= idx_reg + 1'b1;
        end
        if (state_reg == ST_MEAN)
        begin
            mag_reg <= ts[SUM_W-1] ? SUM_W'(-ts) : SUM_W'(ts);
            mneg_reg <= ts[SUM_W-1];
        end
    end

    assign out_ch.phase = phase_reg;
    assign out_ch.container_release_pulse = cpulse_reg;
    assign out_ch.payload_release_pulse = ppulse_reg;
    assign out_ch.container_dropped = cflag_reg;
    assign out_ch.payload_dropped = pflag_reg;
    assign out_ch.glider_deployed = gflag_reg;
    assign out_ch.mean_rate = mneg_reg ? 16'(-mean_mag) : 16'(mean_mag);
endmodule
`default_nettype wire

/* src/fpd_divider.sv */
`timescale 1ns / 1ps
`default_nettype none
module fpd_divider
    import fpd_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire div_req_t req,
    output div_rsp_t rsp
);
    logic [NUM_W-1:0] quo_reg, quo_next;
    logic [DEN_W:0] rem_reg, rem_next;
    logic [DEN_W-1:0] den_reg, den_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic busy_reg, busy_next;
    logic done_reg, done_next;
    logic [DEN_W:0] trial;
    logic [DEN_W:0] shifted;

    // restoring division, one quotient bit a cycle
    always_comb
    begin
        quo_next = quo_reg;
        rem_next = rem_reg;
        den_next = den_reg;
        cnt_next = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        shifted = {rem_reg[DEN_W-1:0], quo_reg[NUM_W-1]};
        trial = shifted - {1'b0, den_reg};
        if (req.start)
        begin
            quo_next = req.num_mag;
            rem_next = '0;
            den_next = req.den;
            cnt_next = CNT_W'(NUM_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!trial[DEN_W])
            begin
                rem_next = trial;
                quo_next = {quo_reg[NUM_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted;
                quo_next = {quo_reg[NUM_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign rsp.done = done_reg;
    assign rsp.quo = quo_reg;
endmodule
`default_nettype wire

/* src/fpd_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
module fpd_props
    import fpd_pkg::*;
(
    input wire logic clk,
    input wire logic rst_n,
    input wire logic in_valid,
    input wire logic in_ready,
    input wire logic out_valid,
    input wire logic out_ready,
    input wire logic [2:0] phase,
    input wire logic cpulse,
    input wire logic ppulse,
    input wire logic cflag,
    input wire logic pflag
);
    a_excl: assert property (@(posedge clk) disable iff (!rst_n) !(in_ready && out_valid))
        else $error("ready while result pending");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(phase))
        else $error("result changed under stall");
    a_cp: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && cpulse |-> cflag && phase == PH_PROBE)
        else $error("container pulse without release");
    a_pp: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && ppulse |-> pflag && phase == PH_PAYLOAD)
        else $error("payload pulse without release");
    a_one: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("second transaction taken");
endmodule

bind flight_phase_detector fpd_props u_chk (
    .clk(clk), .rst_n(rst_n), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .phase(out_ch.phase),
    .cpulse(out_ch.container_release_pulse), .ppulse(out_ch.payload_release_pulse),
    .cflag(out_ch.container_dropped), .pflag(out_ch.payload_dropped)
);
`default_nettype wire

/* dv/fpd_checker.sv */
`timescale 1ns / 1ps
module fpd_checker
    import fpd_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    fpd_in_if in_ch,
    fpd_out_if out_ch,
    input  wire logic cfg_we,
    input  wire logic [2:0] cfg_index,
    input  wire logic [20:0] cfg_data,
    output int fail_count,
    output int pending
);
    typedef struct packed {
        logic [2:0] phase;
        logic cpulse;
        logic ppulse;
        logic cflag;
        logic pflag;
        logic glider;
        logic signed [15:0] mean;
    } phase_report_t;

    phase_report_t expected_reports[$];

    logic signed [31:0] rates [RING_DEPTH];
    int unsigned slot;
    phase_t cur_phase;
    logic signed [20:0] held_alt;
    logic [31:0] prev_time;
    logic container_done, payload_done, glider_on;
    logic signed [15:0] lim_launch, lim_apogee, lim_landed;
    logic signed [20:0] drop_height;
    logic [6:0] drop_percent;

    function automatic longint ring_trimmed_sum();
        longint s;
        longint hi;
        longint lo;
        s = 0;
        hi = rates[0];
        lo = rates[0];
        for (int i = 0; i < RING_DEPTH; i++)
        begin
            s += rates[i];
            if (rates[i] > hi) hi = rates[i];
            if (rates[i] < lo) lo = rates[i];
        end
        return s - hi - lo;
    endfunction

    task automatic advance_flight(input logic kind, input logic signed [20:0] alt,
        input logic [31:0] now, input logic signed [20:0] peak,
        input logic apo_sent, input logic pay_sent);
        longint num;
        longint r;
        longint ts;
        longint dv;
        phase_report_t rep;
        dv = RING_DEPTH - 2;
        rep = '0;
        if (!kind)
        begin
            for (int i = 0; i < RING_DEPTH; i++) rates[i] = 0;
            held_alt = alt;
            prev_time = now;
        end
        else
        begin
            if (now != prev_time)
            begin
                num = (longint'(alt) - longint'(held_alt)) * 1000;
                r = num / longint'({32'd0, now - prev_time});
                if (r > 32767) r = 32767;
                if (r < -32768) r = -32768;
                if (slot >= RING_DEPTH) slot = 0;
                rates[slot] = r;
                slot = (slot + 1) % RING_DEPTH;
                prev_time = now;
                held_alt = alt;
            end
            ts = ring_trimmed_sum();
            case (cur_phase)
                PH_PAD: if (ts > longint'(lim_launch) * dv) cur_phase = PH_ASCENT;
                PH_ASCENT: if (ts < longint'(lim_apogee) * dv) cur_phase = PH_APOGEE;
                PH_APOGEE: if (apo_sent) cur_phase = PH_DESCENT;
                PH_DESCENT:
                    if (longint'(alt) * 100 <= longint'({1'b0, drop_percent}) * longint'(peak))
                    begin
                        cur_phase = PH_PROBE;
                        rep.cpulse = 1;
                        container_done = 1;
                        glider_on = 1;
                    end
                PH_PROBE:
                    if (alt <= drop_height || ts > longint'(lim_landed) * dv)
                    begin
                        cur_phase = PH_PAYLOAD;
                        rep.ppulse = 1;
                        payload_done = 1;
                    end
                PH_PAYLOAD:
                    if (ts > longint'(lim_landed) * dv && pay_sent)
                    begin
                        cur_phase = PH_LANDED;
                        glider_on = 0;
                    end
                default: ;
            endcase
        end
        rep.phase = cur_phase;
        rep.cflag = container_done;
        rep.pflag = payload_done;
        rep.glider = glider_on;
        rep.mean = 16'(ring_trimmed_sum() / dv);
        expected_reports.push_back(rep);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        phase_report_t got;
        phase_report_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < RING_DEPTH; i++) rates[i] = 0;
            slot = 0;
            cur_phase = PH_PAD;
            held_alt = 0;
            prev_time = 0;
            container_done = 0;
            payload_done = 0;
            glider_on = 0;
            lim_launch = 500;
            lim_apogee = -50;
            lim_landed = -20;
            drop_height = 300;
            drop_percent = 80;
            expected_reports.delete();
            fail_count = 0;
        end
        else
        begin
            if (cfg_we)
                case (cfg_index)
                    CFG_LAUNCH: lim_launch = cfg_data[15:0];
                    CFG_APOGEE: lim_apogee = cfg_data[15:0];
                    CFG_LANDED: lim_landed = cfg_data[15:0];
                    CFG_HEIGHT: drop_height = cfg_data;
                    CFG_PERCENT: drop_percent = cfg_data[6:0];
                    default: ;
                endcase
            if (out_ch.valid && out_ch.ready)
            begin
                got = {out_ch.phase, out_ch.container_release_pulse,
                    out_ch.payload_release_pulse, out_ch.container_dropped,
                    out_ch.payload_dropped, out_ch.glider_deployed, out_ch.mean_rate};
                if (expected_reports.size() == 0)
                begin
                    $display("%0t: unexpected transaction, expected none actual %p",
                        $time, got);
                    fail_count++;
                end
                else
                begin
                    want = expected_reports.pop_front();
                    if (got.phase !== want.phase)
                        $display("%0t: phase expected %0d actual %0d", $time, want.phase, got.phase);
                    if (got.cpulse !== want.cpulse)
                        $display("%0t: container pulse expected %0b actual %0b", $time,
                            want.cpulse, got.cpulse);
                    if (got.ppulse !== want.ppulse)
                        $display("%0t: payload pulse expected %0b actual %0b", $time,
                            want.ppulse, got.ppulse);
                    if (got.cflag !== want.cflag)
                        $display("%0t: container flag expected %0b actual %0b", $time,
                            want.cflag, got.cflag);
                    if (got.pflag !== want.pflag)
                        $display("%0t: payload flag expected %0b actual %0b", $time,
                            want.pflag, got.pflag);
                    if (got.glider !== want.glider)
                        $display("%0t: glider expected %0b actual %0b", $time,
                            want.glider, got.glider);
                    if (got.mean !== want.mean)
                        $display("%0t: mean rate expected %0d actual %0d", $time,
                            want.mean, got.mean);
                    if (got !== want) fail_count++;
                end
            end
            if (in_ch.valid && in_ch.ready)
                advance_flight(in_ch.kind, in_ch.altitude, in_ch.time_ms,
                    in_ch.peak_altitude, in_ch.apogee_sent, in_ch.payload_release_sent);
        end
        pending = expected_reports.size();
    end
endmodule

/* dv/testbench.sv */
`timescale 1ns / 1ps
module testbench;
    import fpd_pkg::*;

    logic clk = 0;
    logic rst_n = 0;
    logic cfg_we = 0;
    logic [2:0] cfg_index = '0;
    logic [20:0] cfg_data = '0;
    int fail_count;
    int pending;
    int send_idle_pct;
    int recv_stall_pct;
    int quiet_cycles;
    logic [31:0] clock_ms;
    logic signed [20:0] height;
    logic signed [20:0] apex;

    fpd_in_if in_ch();
    fpd_out_if out_ch();

    flight_phase_detector dut (
        .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    fpd_checker checker_i (
        .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .fail_count(fail_count), .pending(pending)
    );

    always
    begin
        #10 clk = 1;
        #10 clk = 0;
    end

    initial
    begin
        in_ch.valid = 0;
        in_ch.kind = 0;
        in_ch.altitude = '0;
        in_ch.time_ms = '0;
        in_ch.peak_altitude = '0;
        in_ch.apogee_sent = 0;
        in_ch.payload_release_sent = 0;
        out_ch.ready = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
    end

    always @(posedge clk)
        out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);

    always @(posedge clk)
    begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles > 20000)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // valid stays high into the next call, so back-to-back calls keep the channel busy
    task automatic send_item(input logic kind, input logic signed [20:0] alt,
        input logic [31:0] now, input logic signed [20:0] peak,
        input logic apo, input logic pay);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_ch.valid <= 0;
            @(posedge clk);
        end
        in_ch.valid <= 1;
        in_ch.kind <= kind;
        in_ch.altitude <= alt;
        in_ch.time_ms <= now;
        in_ch.peak_altitude <= peak;
        in_ch.apogee_sent <= apo;
        in_ch.payload_release_sent <= pay;
        do @(posedge clk); while (!in_ch.ready);
    endtask

    task automatic drain_results();
        in_ch.valid <= 0;
        do
        begin
            @(posedge clk);
            #1;
        end
        while (pending != 0);
        repeat (60) @(posedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [20:0] val);
        cfg_we <= 1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
    endtask

    task automatic random_regs();
        write_reg(CFG_LAUNCH, 21'($urandom_range(1500)));
        write_reg(CFG_APOGEE, -21'($urandom_range(300)));
        write_reg(CFG_LANDED, -21'($urandom_range(100)));
        write_reg(CFG_HEIGHT, 21'($urandom_range(2000)));
        write_reg(CFG_PERCENT, 21'($urandom_range(100)));
        cfg_we <= 0;
    endtask

    // one flight profile: pad, climb, descend, settle
    task automatic fly_profile(input int steps);
        int climb;
        int dt;
        climb = $urandom_range(3000, 200);
        height = 21'(int'($urandom_range(2000)) - 1000);
        apex = height;
        clock_ms = clock_ms + $urandom_range(1000);
        send_item(0, height, clock_ms, apex, 0, 0);
        for (int i = 0; i < steps; i++)
        begin
            dt = ($urandom_range(19) == 0) ? 0 : $urandom_range(200, 20);
            clock_ms += dt;
            if (i < steps / 3)
                height += 21'(climb * dt / 1000 + int'($urandom_range(20)) - 10);
            else if (i > steps * 4 / 5)
                height += 21'(int'($urandom_range(4)) - 2);
            else
                height -= 21'(climb * dt / 1000 + int'($urandom_range(20)) - 10);
            if (height > apex) apex = height;
            send_item(1, height, clock_ms, apex, $urandom_range(3) != 0,
                $urandom_range(3) != 0);
        end
    endtask

    task automatic noise_item();
        send_item($urandom_range(7) != 0, 21'($urandom), $urandom,
            21'($urandom), $urandom_range(1), $urandom_range(1));
    endtask

    initial
    begin
        clock_ms = 0;
        quiet_cycles = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // directed: field extremes, zero elapsed time, tick wrap, saturation
        send_item(1, 0, 0, 0, 0, 0);
        send_item(0, -21'sd100000, 32'hFFFF_FFF0, 21'sd1000000, 1, 1);
        send_item(1, 21'sd1000000, 32'h0000_0010, 21'sd1000000, 1, 1);
        send_item(1, -21'sd100000, 32'h0000_0011, -21'sd100000, 0, 1);
        send_item(1, 21'h0FFFFF, 32'h0000_0012, 21'h100000, 1, 0);
        send_item(1, 21'h100000, 32'h0000_0012, 21'h0FFFFF, 1, 1);
        send_item(1, 21'h1FFFFF, 32'hFFFF_FFFF, 21'h1FFFFF, 0, 0);
        send_item(0, 0, 32'h0, 0, 0, 0);
        clock_ms = 0;
        fly_profile(16);
        drain_results();

        write_reg(CFG_LAUNCH, 21'h007FFF);
        write_reg(CFG_APOGEE, 21'h008000);
        write_reg(CFG_LANDED, 21'h008000);
        write_reg(CFG_HEIGHT, 21'h100000);
        write_reg(CFG_PERCENT, 21'd127);
        cfg_we <= 0;
        fly_profile(10);
        drain_results();
        write_reg(CFG_LAUNCH, 21'h008000);
        write_reg(CFG_APOGEE, 21'h007FFF);
        write_reg(CFG_LANDED, 21'h007FFF);
        write_reg(CFG_HEIGHT, 21'h0FFFFF);
        write_reg(CFG_PERCENT, 21'd0);
        cfg_we <= 0;
        fly_profile(10);
        drain_results();
        rst_n <= 1;

        for (int ph = 0; ph < 4; ph++)
        begin
            send_idle_pct = (ph == 1) ? 70 : (ph == 3) ? 35 : 0;
            recv_stall_pct = (ph == 2) ? 70 : (ph == 3) ? 35 : 0;
            random_regs();
            for (int k = 0; k < 5; k++)
            begin
                fly_profile($urandom_range(50, 30));
                repeat ($urandom_range(4)) noise_item();
            end
            drain_results();
        end

        drain_results();
        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule
